// ----- rtl/secb_pkg.sv -----
`timescale 1ns / 1ps

package secb_pkg;

	localparam int unsigned WHEELS    = 4;
	localparam int unsigned OUT_WIDTH = 32;
	localparam int unsigned DIR_WIDTH = 2;
	localparam int unsigned IDX_WIDTH = 2;

	typedef enum logic [1:0] {
		OP_SAMPLE      = 2'd0,
		OP_CLEAR_DELTA = 2'd1,
		OP_CLEAR_TOTAL = 2'd2,
		OP_READ        = 2'd3
	} opcode_t;

	typedef logic signed [DIR_WIDTH-1:0] dir_t;

	localparam dir_t DIR_FWD = 2'sb01;
	localparam dir_t DIR_REV = 2'sb11;
	localparam dir_t DIR_SAT = 2'sb10;

	// saturate the out-of-range pattern to -1
	function automatic dir_t decode_dir(input logic [DIR_WIDTH-1:0] bits);
		dir_t d;
		d = dir_t'(bits);
		if (d == DIR_SAT) begin
			d = DIR_REV;
		end
		return d;
	endfunction

endpackage

// ----- rtl/signed_edge_counter_bank_unit.sv -----
`timescale 1ns / 1ps

// Bank of four single-channel wheel encoder pulse counters. Each item either
// samples the four encoder lines (a rising edge adds the wheel's direction,
// -1, 0 or +1, to its delta and total counters), reads and clears the deltas,
// clears the totals, or only reads; the first sample after reset only loads
// the line levels. Each item returns one result holding all eight counters as
// they stood before the item, sign-extended or cut to 32 bits. One item is
// accepted every cycle unless a held, stalled result blocks the input; an item
// is held in the input register while the edge detect and counter add run,
// and the result register takes the counters once it is free. Direction
// registers may be written only while idle.
module signed_edge_counter_bank_unit #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [1:0]                               opcode,
	input  logic [3:0]                               pin_levels,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    delta_wheel0,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    delta_wheel1,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    delta_wheel2,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    delta_wheel3,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    total_wheel0,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    total_wheel1,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    total_wheel2,
	output logic signed [secb_pkg::OUT_WIDTH-1:0]    total_wheel3,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [secb_pkg::IDX_WIDTH-1:0]           cfg_index,
	input  logic [secb_pkg::DIR_WIDTH-1:0]           cfg_data
);

	logic                              valid_s1;
	secb_pkg::opcode_t                 opcode_s1;
	logic [secb_pkg::WHEELS-1:0]       pins_s1;

	logic                              out_valid_q;
	logic [secb_pkg::OUT_WIDTH-1:0]    out_delta_q [secb_pkg::WHEELS];
	logic [secb_pkg::OUT_WIDTH-1:0]    out_total_q [secb_pkg::WHEELS];

	secb_pkg::dir_t                    dir_q       [secb_pkg::WHEELS];
	logic [secb_pkg::WHEELS-1:0]       prev_q;
	logic                              primed_q;
	logic [COUNT_WIDTH-1:0]            delta_q     [secb_pkg::WHEELS];
	logic [COUNT_WIDTH-1:0]            total_q     [secb_pkg::WHEELS];
	logic [COUNT_WIDTH-1:0]            delta_d     [secb_pkg::WHEELS];
	logic [COUNT_WIDTH-1:0]            total_d     [secb_pkg::WHEELS];

	logic                              adv;
	logic                              cfg_wr;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= secb_pkg::opcode_t'(opcode);
			pins_s1   <= pin_levels;
		end
	end

	// counter update
	always_comb begin
		logic [COUNT_WIDTH-1:0] step;
		logic                   rise;
		for (int w = 0; w < secb_pkg::WHEELS; w++) begin
			step       = COUNT_WIDTH'(dir_q[w]);
			rise       = pins_s1[w] && !prev_q[w];
			delta_d[w] = delta_q[w];
			total_d[w] = total_q[w];
			case (opcode_s1)
				secb_pkg::OP_SAMPLE: begin
					if (primed_q && rise) begin
						delta_d[w] = delta_q[w] + step;
						total_d[w] = total_q[w] + step;
					end
				end
				secb_pkg::OP_CLEAR_DELTA: begin
					delta_d[w] = '0;
				end
				secb_pkg::OP_CLEAR_TOTAL: begin
					total_d[w] = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			primed_q <= 1'b0;
			for (int w = 0; w < secb_pkg::WHEELS; w++) begin
				delta_q[w] <= '0;
				total_q[w] <= '0;
				dir_q[w]   <= secb_pkg::DIR_FWD;
			end
		end else begin
			if (adv) begin
				for (int w = 0; w < secb_pkg::WHEELS; w++) begin
					delta_q[w] <= delta_d[w];
					total_q[w] <= total_d[w];
				end
				if (opcode_s1 == secb_pkg::OP_SAMPLE) begin
					prev_q   <= pins_s1;
					primed_q <= 1'b1;
				end
			end
			if (cfg_wr) begin
				dir_q[cfg_index] <= secb_pkg::decode_dir(cfg_data);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int w = 0; w < secb_pkg::WHEELS; w++) begin
				out_delta_q[w] <= secb_pkg::OUT_WIDTH'($signed(delta_q[w]));
				out_total_q[w] <= secb_pkg::OUT_WIDTH'($signed(total_q[w]));
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign delta_wheel0 = out_delta_q[0];
	assign delta_wheel1 = out_delta_q[1];
	assign delta_wheel2 = out_delta_q[2];
	assign delta_wheel3 = out_delta_q[3];
	assign total_wheel0 = out_total_q[0];
	assign total_wheel1 = out_total_q[1];
	assign total_wheel2 = out_total_q[2];
	assign total_wheel3 = out_total_q[3];

`ifndef SYNTHESIS
	a_clear_delta: assert property (@(posedge clk) disable iff (!arst_n)
		adv && opcode_s1 == secb_pkg::OP_CLEAR_DELTA |=>
			delta_q[0] == '0 && delta_q[1] == '0 && delta_q[2] == '0 && delta_q[3] == '0)
		else $error("delta counters not cleared");

	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		adv && opcode_s1 == secb_pkg::OP_CLEAR_TOTAL |=>
			total_q[0] == '0 && total_q[1] == '0 && total_q[2] == '0 && total_q[3] == '0)
		else $error("total counters not cleared");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && opcode_s1 == secb_pkg::OP_READ |=>
			$stable(delta_q[0]) && $stable(total_q[0]) && $stable(prev_q) && $stable(primed_q))
		else $error("read-only item changed state");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_primed_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(primed_q) |-> $past(adv && opcode_s1 == secb_pkg::OP_SAMPLE))
		else $error("primed set without a sample item");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned    PHASE_ITEMS = 255;
	localparam int unsigned    LONG_HOLD   = 200;
	localparam int unsigned    DRAIN_WAIT  = 8;
	localparam secb_pkg::dir_t DIR_OFF     = 2'sb00;

	typedef struct packed {
		secb_pkg::opcode_t op;
		logic [3:0]        pins;
	} encoder_item_t;

	typedef struct packed {
		logic [secb_pkg::WHEELS-1:0][secb_pkg::OUT_WIDTH-1:0] delta;
		logic [secb_pkg::WHEELS-1:0][secb_pkg::OUT_WIDTH-1:0] total;
	} counter_snapshot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = secb_pkg::OP_READ;
	logic [3:0] pin_levels = 4'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [secb_pkg::OUT_WIDTH-1:0] delta_wheel0, delta_wheel1;
	logic signed [secb_pkg::OUT_WIDTH-1:0] delta_wheel2, delta_wheel3;
	logic signed [secb_pkg::OUT_WIDTH-1:0] total_wheel0, total_wheel1;
	logic signed [secb_pkg::OUT_WIDTH-1:0] total_wheel2, total_wheel3;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [secb_pkg::IDX_WIDTH-1:0] cfg_index = '0;
	logic [secb_pkg::DIR_WIDTH-1:0] cfg_data = '0;

	signed_edge_counter_bank_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.delta_wheel0 (delta_wheel0),
		.delta_wheel1 (delta_wheel1),
		.delta_wheel2 (delta_wheel2),
		.delta_wheel3 (delta_wheel3),
		.total_wheel0 (total_wheel0),
		.total_wheel1 (total_wheel1),
		.total_wheel2 (total_wheel2),
		.total_wheel3 (total_wheel3),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	encoder_item_t     pending_items[$];
	counter_snapshot_t expected_snapshots[$];
	encoder_item_t     offered;

	int                                    wheel_step[secb_pkg::WHEELS];
	logic [3:0]                            prev_levels;
	logic                                  levels_primed;
	logic signed [secb_pkg::OUT_WIDTH-1:0] delta_count[secb_pkg::WHEELS];
	logic signed [secb_pkg::OUT_WIDTH-1:0] total_count[secb_pkg::WHEELS];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        send_pause = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned error_count = 0;
	int unsigned results_checked = 0;
	int unsigned rising_edges = 0;
	int unsigned settings_used = 0;
	int unsigned accepted_by_op[4];

	function automatic int step_of(input logic [secb_pkg::DIR_WIDTH-1:0] bits);
		case (secb_pkg::dir_t'(bits))
			DIR_OFF: return 0;
			secb_pkg::DIR_FWD: return 1;
			default: return -1;
		endcase
	endfunction

	// snapshot the counters, then apply the item
	task automatic count_bank_step(input encoder_item_t it);
		counter_snapshot_t snap;
		logic [3:0]        rising;
		for (int i = 0; i < secb_pkg::WHEELS; i++) begin
			snap.delta[i] = delta_count[i];
			snap.total[i] = total_count[i];
		end
		expected_snapshots.push_back(snap);
		accepted_by_op[it.op]++;
		case (it.op)
			secb_pkg::OP_SAMPLE: begin
				if (levels_primed) begin
					rising = it.pins & ~prev_levels;
					for (int i = 0; i < secb_pkg::WHEELS; i++) begin
						if (rising[i]) begin
							delta_count[i] = delta_count[i] + wheel_step[i];
							total_count[i] = total_count[i] + wheel_step[i];
							rising_edges++;
						end
					end
				end
				levels_primed = 1'b1;
				prev_levels = it.pins;
			end
			secb_pkg::OP_CLEAR_DELTA: begin
				for (int i = 0; i < secb_pkg::WHEELS; i++) delta_count[i] = '0;
			end
			secb_pkg::OP_CLEAR_TOTAL: begin
				for (int i = 0; i < secb_pkg::WHEELS; i++) total_count[i] = '0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				count_bank_step(offered);
			end
			if (!in_valid || !in_stall) begin
				if (!send_pause && pending_items.size() != 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					in_valid <= 1'b1;
					opcode <= offered.op;
					pin_levels <= offered.pins;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		counter_snapshot_t want;
		counter_snapshot_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.delta = {delta_wheel3, delta_wheel2, delta_wheel1, delta_wheel0};
				got.total = {total_wheel3, total_wheel2, total_wheel1, total_wheel0};
				if (expected_snapshots.size() == 0) begin
					$display("%0t: unexpected result item", $time);
					error_count++;
				end else begin
					want = expected_snapshots.pop_front();
					results_checked++;
					for (int i = 0; i < secb_pkg::WHEELS; i++) begin
						if (got.delta[i] !== want.delta[i]) begin
							$display("%0t: delta_wheel%0d expected %0d actual %0d", $time, i,
							         $signed(want.delta[i]), $signed(got.delta[i]));
							error_count++;
						end
						if (got.total[i] !== want.total[i]) begin
							$display("%0t: total_wheel%0d expected %0d actual %0d", $time, i,
							         $signed(want.total[i]), $signed(got.total[i]));
							error_count++;
						end
					end
				end
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic queue_item(input secb_pkg::opcode_t op, input logic [3:0] pins);
		encoder_item_t it;
		it.op = op;
		it.pins = pins;
		pending_items.push_back(it);
	endtask

	function automatic encoder_item_t random_item();
		encoder_item_t it;
		int unsigned   pick;
		pick = $urandom_range(99);
		it.pins = 4'($urandom);
		if (pick < 70) it.op = secb_pkg::OP_SAMPLE;
		else if (pick < 80) it.op = secb_pkg::OP_CLEAR_DELTA;
		else if (pick < 85) it.op = secb_pkg::OP_CLEAR_TOTAL;
		else it.op = secb_pkg::OP_READ;
		return it;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_snapshots.size() != 0 || in_valid)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// dirs holds {wheel3, wheel2, wheel1, wheel0}
	task automatic program_directions(input logic [4*secb_pkg::DIR_WIDTH-1:0] dirs);
		@(posedge clk);
		for (int i = 0; i < secb_pkg::WHEELS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= secb_pkg::IDX_WIDTH'(i);
			cfg_data <= dirs[i*secb_pkg::DIR_WIDTH +: secb_pkg::DIR_WIDTH];
			do @(posedge clk); while (!cfg_ready);
			wheel_step[i] = step_of(dirs[i*secb_pkg::DIR_WIDTH +: secb_pkg::DIR_WIDTH]);
		end
		cfg_valid <= 1'b0;
		settings_used++;
		@(negedge clk);
	endtask

	initial begin
		logic [4*secb_pkg::DIR_WIDTH-1:0] phase_dirs[6];
		phase_dirs = '{8'b01010101, 8'b11111111, 8'b00000000, 8'b10101010,
		               8'($urandom), 8'($urandom)};
		for (int i = 0; i < secb_pkg::WHEELS; i++) begin
			wheel_step[i] = 1;
			delta_count[i] = '0;
			total_count[i] = '0;
		end
		for (int i = 0; i < 4; i++) accepted_by_op[i] = 0;
		prev_levels = 4'd0;
		levels_primed = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		queue_item(secb_pkg::OP_READ, 4'h0);
		queue_item(secb_pkg::OP_CLEAR_DELTA, 4'hF);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_SAMPLE, 4'h0);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_CLEAR_TOTAL, 4'h0);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_SAMPLE, 4'h0);
		queue_item(secb_pkg::OP_SAMPLE, 4'h5);
		queue_item(secb_pkg::OP_SAMPLE, 4'hA);
		queue_item(secb_pkg::OP_READ, 4'h5);
		queue_item(secb_pkg::OP_CLEAR_DELTA, 4'h0);
		queue_item(secb_pkg::OP_READ, 4'hA);
		wait_idle();

		// reverse, off, forward and the saturating pattern at once
		program_directions({secb_pkg::DIR_SAT, secb_pkg::DIR_FWD, DIR_OFF,
		                    secb_pkg::DIR_REV});
		queue_item(secb_pkg::OP_SAMPLE, 4'h0);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_SAMPLE, 4'h0);
		queue_item(secb_pkg::OP_SAMPLE, 4'hF);
		queue_item(secb_pkg::OP_READ, 4'h3);
		queue_item(secb_pkg::OP_CLEAR_TOTAL, 4'hC);
		queue_item(secb_pkg::OP_CLEAR_DELTA, 4'h0);
		queue_item(secb_pkg::OP_READ, 4'hF);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			program_directions(phase_dirs[p]);
			send_idle_pct = (p < 2) ? 30 : (p < 4) ? 54 : 0;
			recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 30 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
			if (p == 1) begin
				// back up the pipe while items keep coming
				while (pending_items.size() > PHASE_ITEMS / 2) @(negedge clk);
				hold_requests++;
			end
			if (p == 3) begin
				while (pending_items.size() > PHASE_ITEMS / 2) @(negedge clk);
				send_pause = 1'b1;
				while (expected_snapshots.size() != 0 || in_valid) @(negedge clk);
				send_pause = 1'b0;
			end
			wait_idle();
		end

		$display("Ran %0d sample, %0d delta-clear, %0d total-clear, %0d read items",
		         accepted_by_op[secb_pkg::OP_SAMPLE], accepted_by_op[secb_pkg::OP_CLEAR_DELTA],
		         accepted_by_op[secb_pkg::OP_CLEAR_TOTAL], accepted_by_op[secb_pkg::OP_READ]);
		$display("Checked %0d results, %0d counted edges, %0d direction settings",
		         results_checked, rising_edges, settings_used);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
